// ===== design/dupd_pkg.sv =====
// ---------------------------------------------------------------------------
// dupd_pkg
// Shared types, character constants and lookup functions for the data URI
// payload decoder.
// ---------------------------------------------------------------------------
package dupd_pkg;

    // Input item: one URI character.
    typedef struct packed {
        logic [7:0] char_in;
        logic       char_last;
    } dupd_in_t;

    // Result item: one decoded byte or the final status.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       done_res;
        logic [1:0] status;
    } dupd_out_t;

    // All results caused by one input item, queued between front and back.
    typedef struct packed {
        logic [1:0]      byte_count;
        logic [2:0][7:0] bytes;
        logic            has_status;
        logic [1:0]      status;
    } dupd_entry_t;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_DATA  = 2'd1;
    localparam logic [1:0] ST_NO_COMMA  = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [7:0] CH_PCT   = 8'h25; // '%'
    localparam logic [7:0] CH_COMMA = 8'h2c; // ','
    localparam logic [7:0] CH_LOW_B = 8'h62; // 'b'

    localparam int unsigned PREFIX_LEN = 5;
    localparam int unsigned WORD_LEN   = 6;

    // "data:" by position
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h64; // d
            3'd1:    ch = 8'h61; // a
            3'd2:    ch = 8'h74; // t
            3'd3:    ch = 8'h61; // a
            3'd4:    ch = 8'h3a; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "base64" by position
    function automatic logic [7:0] word_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h62; // b
            3'd1:    ch = 8'h61; // a
            3'd2:    ch = 8'h73; // s
            3'd3:    ch = 8'h65; // e
            3'd4:    ch = 8'h36; // 6
            3'd5:    ch = 8'h34; // 4
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        if (c >= 8'h41 && c <= 8'h5a)
            r = c + 8'h20;
        else
            r = c;
        return r;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        else
            r = 5'd0;
        return r;
    endfunction

    // {valid, value}; padding and everything outside the alphabet is invalid
    function automatic logic [6:0] b64_val(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5a)
            r = {1'b1, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7a)
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        else if (c == 8'h2b)
            r = {1'b1, 6'd62};
        else if (c == 8'h2f)
            r = {1'b1, 6'd63};
        else
            r = 7'd0;
        return r;
    endfunction

endpackage

// ===== design/dupd_front.sv =====
// ---------------------------------------------------------------------------
// dupd_front
// Accepts one character per cycle while push_ready is high, tracks
// prefix/header/payload state and produces the bundle of results it causes.
// ---------------------------------------------------------------------------
module dupd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dupd_pkg::dupd_in_t   in_item,
    input  logic                 push_ready,
    output logic                 push_valid,
    output dupd_pkg::dupd_entry_t push_entry
);
    import dupd_pkg::*;

    localparam logic [1:0] PH_PREFIX  = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_REJECT  = 2'd3;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_PCT  = 2'd1;
    localparam logic [1:0] ESC_HI   = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  prefix_count_reg, prefix_count_next;
    logic [2:0]  match_count_reg, match_count_next;
    logic        b64_mode_reg, b64_mode_next;
    logic [11:0] acc_reg, acc_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic [1:0]  esc_reg, esc_next;
    logic [7:0]  esc_hi_reg, esc_hi_next;
    logic        any_byte_reg, any_byte_next;

    logic [7:0]       c;
    logic [4:0]       hx;
    logic [4:0]       hi_hx;
    logic [6:0]       bv;
    logic [2:0]       match;
    logic [3:0]       cnt_sum;
    logic [11:0]      shifted;
    logic [2:0][7:0]  bytes;
    logic [1:0]       n;
    logic [1:0]       st;
    logic             accept;

    assign c        = in_item.char_in;
    assign hx       = hex_val(c);
    assign hi_hx    = hex_val(esc_hi_reg);
    assign bv       = b64_val(c);
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next        = phase_reg;
        prefix_count_next = prefix_count_reg;
        match_count_next  = match_count_reg;
        b64_mode_next     = b64_mode_reg;
        acc_next          = acc_reg;
        bit_count_next    = bit_count_reg;
        esc_next          = esc_reg;
        esc_hi_next       = esc_hi_reg;
        bytes             = '0;
        n                 = 2'd0;
        match             = 3'd0;
        cnt_sum           = 4'd0;
        shifted           = 12'd0;
        st                = ST_OK;

        unique case (phase_reg)
            PH_PREFIX:
            begin
                if (to_lower(c) == prefix_char(prefix_count_reg))
                begin
                    prefix_count_next = prefix_count_reg + 3'd1;
                    if (prefix_count_reg == 3'(PREFIX_LEN - 1))
                        phase_next = PH_HEADER;
                end
                else
                begin
                    phase_next = PH_REJECT;
                end
            end
            PH_HEADER:
            begin
                if (c == CH_COMMA)
                begin
                    phase_next = PH_PAYLOAD;
                end
                else if (!b64_mode_reg)
                begin
                    if (match_count_reg < 3'(WORD_LEN) && c == word_char(match_count_reg))
                        match = match_count_reg + 3'd1;
                    else
                        match = (c == CH_LOW_B) ? 3'd1 : 3'd0;
                    match_count_next = match;
                    if (match == 3'(WORD_LEN))
                        b64_mode_next = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                if (b64_mode_reg)
                begin
                    if (bv[6])
                    begin
                        acc_next = {acc_reg[5:0], bv[5:0]};
                        cnt_sum  = {1'b0, bit_count_reg} + 4'd6;
                        if (cnt_sum >= 4'd8)
                        begin
                            bit_count_next = 3'(cnt_sum - 4'd8);
                            shifted        = acc_next >> bit_count_next;
                            bytes[n]       = shifted[7:0];
                            n              = n + 2'd1;
                        end
                        else
                        begin
                            bit_count_next = cnt_sum[2:0];
                        end
                    end
                end
                else
                begin
                    unique case (esc_reg)
                        ESC_PCT:
                        begin
                            if (hx[4])
                            begin
                                esc_hi_next = c;
                                esc_next    = ESC_HI;
                            end
                            else
                            begin
                                esc_next = ESC_NONE;
                                bytes[n] = CH_PCT;
                                n        = n + 2'd1;
                                if (c == CH_PCT)
                                    esc_next = ESC_PCT;
                                else
                                begin
                                    bytes[n] = c;
                                    n        = n + 2'd1;
                                end
                            end
                        end
                        ESC_HI:
                        begin
                            esc_next = ESC_NONE;
                            if (hx[4])
                            begin
                                bytes[n] = {(hi_hx[4] ? hi_hx[3:0] : 4'd0), hx[3:0]};
                                n        = n + 2'd1;
                            end
                            else
                            begin
                                // bad second digit: flush '%' and the first digit literally
                                bytes[n] = CH_PCT;
                                n        = n + 2'd1;
                                bytes[n] = esc_hi_reg;
                                n        = n + 2'd1;
                                if (c == CH_PCT)
                                    esc_next = ESC_PCT;
                                else
                                begin
                                    bytes[n] = c;
                                    n        = n + 2'd1;
                                end
                            end
                        end
                        default:
                        begin
                            esc_next = ESC_NONE;
                            if (c == CH_PCT)
                                esc_next = ESC_PCT;
                            else
                            begin
                                bytes[n] = c;
                                n        = n + 2'd1;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                // rejected: ignore the rest of the URI
            end
        endcase

        // end of URI: flush a cut-short escape
        if (in_item.char_last && phase_next == PH_PAYLOAD && !b64_mode_next)
        begin
            if (esc_next == ESC_PCT)
            begin
                bytes[n] = CH_PCT;
                n        = n + 2'd1;
            end
            else if (esc_next == ESC_HI)
            begin
                bytes[n] = CH_PCT;
                n        = n + 2'd1;
                bytes[n] = esc_hi_next;
                n        = n + 2'd1;
            end
            esc_next = ESC_NONE;
        end

        any_byte_next = any_byte_reg || (n != 2'd0);

        if (phase_next == PH_PREFIX || phase_next == PH_REJECT)
            st = ST_NOT_DATA;
        else if (phase_next == PH_HEADER)
            st = ST_NO_COMMA;
        else
            st = any_byte_next ? ST_OK : ST_EMPTY;
    end

    always_comb
    begin
        push_entry.byte_count = n;
        push_entry.bytes      = bytes;
        push_entry.has_status = in_item.char_last;
        push_entry.status     = st;
    end

    assign push_valid = accept && ((n != 2'd0) || in_item.char_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PREFIX;
            prefix_count_reg <= 3'd0;
            match_count_reg  <= 3'd0;
            b64_mode_reg     <= 1'b0;
            acc_reg          <= 12'd0;
            bit_count_reg    <= 3'd0;
            esc_reg          <= ESC_NONE;
            esc_hi_reg       <= 8'd0;
            any_byte_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (in_item.char_last)
            begin
                // URI done: back to the start for the next one
                phase_reg        <= PH_PREFIX;
                prefix_count_reg <= 3'd0;
                match_count_reg  <= 3'd0;
                b64_mode_reg     <= 1'b0;
                acc_reg          <= 12'd0;
                bit_count_reg    <= 3'd0;
                esc_reg          <= ESC_NONE;
                esc_hi_reg       <= 8'd0;
                any_byte_reg     <= 1'b0;
            end
            else
            begin
                phase_reg        <= phase_next;
                prefix_count_reg <= prefix_count_next;
                match_count_reg  <= match_count_next;
                b64_mode_reg     <= b64_mode_next;
                acc_reg          <= acc_next;
                bit_count_reg    <= bit_count_next;
                esc_reg          <= esc_next;
                esc_hi_reg       <= esc_hi_next;
                any_byte_reg     <= any_byte_next;
            end
        end
    end

endmodule

// ===== design/dupd_queue.sv =====
// ---------------------------------------------------------------------------
// dupd_queue
// Small FIFO of result bundles between front and back.
// ---------------------------------------------------------------------------
module dupd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  dupd_pkg::dupd_entry_t push_entry,
    output logic                  head_valid,
    input  logic                  pop,
    output dupd_pkg::dupd_entry_t head_entry
);
    import dupd_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dupd_entry_t      entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== design/dupd_back.sv =====
// ---------------------------------------------------------------------------
// dupd_back
// Unpacks queued bundles into single results, one per cycle while out_ready
// allows, through an output register.
// ---------------------------------------------------------------------------
module dupd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  dupd_pkg::dupd_entry_t head_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dupd_pkg::dupd_out_t   out_item
);
    import dupd_pkg::*;

    logic        out_valid_reg;
    dupd_out_t   out_item_reg;
    logic [1:0]  idx_reg, idx_next;
    logic [2:0]  last_idx;
    logic        load;
    logic        at_last;
    dupd_out_t   res;

    // index of the final result in the head bundle
    assign last_idx = {1'b0, head_entry.byte_count} + {2'b00, head_entry.has_status} - 3'd1;
    assign at_last  = ({1'b0, idx_reg} == last_idx);
    assign load     = head_valid && (!out_valid_reg || out_ready);
    assign pop      = load && at_last;
    assign idx_next = at_last ? 2'd0 : idx_reg + 2'd1;

    always_comb
    begin
        if (idx_reg < head_entry.byte_count)
        begin
            res.byte_out   = head_entry.bytes[idx_reg];
            res.byte_valid = 1'b1;
            res.done_res   = 1'b0;
            res.status     = ST_OK;
        end
        else
        begin
            res.byte_out   = 8'd0;
            res.byte_valid = 1'b0;
            res.done_res   = 1'b1;
            res.status     = head_entry.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_item_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== design/data_uri_payload_decoder.sv =====
// ---------------------------------------------------------------------------
// data_uri_payload_decoder
// Streaming data URI decoder: base64 or percent-decoded payload bytes plus a
// final status result per URI.
// ---------------------------------------------------------------------------
// One URI character is taken per cycle on the input channel as long as the
// result queue has room; the front end classifies it in that same cycle
// (prefix "data:" case-insensitive, header scan for "base64" up to the first
// comma, then base64 or percent decoding) and posts the 0 to 4 results it
// causes as one bundle. The back end drains bundles one result per cycle
// while out_ready allows, through a registered output, so the output side
// is the limit: a flushed bad escape yields up to three results and the
// final character up to four. Bundles with more than one result build a
// backlog that the QUEUE_DEPTH-entry queue soaks up before in_ready drops,
// and characters that cause no result (prefix and header) let it drain. A
// character's first result passes through the queue entry and then the
// output register. Status codes on the done result: 0 ok, 1 not a data
// URI, 2 no comma, 3 empty payload. After the flagged last character the
// decoder is back in its reset state for the next URI. QUEUE_DEPTH must be
// at least 2.
// ---------------------------------------------------------------------------
module data_uri_payload_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dupd_pkg::dupd_in_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output dupd_pkg::dupd_out_t out_item
);
    import dupd_pkg::*;

    // front -> queue
    logic        push_valid;
    logic        push_ready;
    dupd_entry_t push_entry;

    // queue -> back
    logic        head_valid;
    logic        pop;
    dupd_entry_t head_entry;

    // Character classification and decode state; one transfer per cycle while the queue has room.
    dupd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    // Decouples the two sides; output stalls block the input only once the queue is full.
    dupd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .head_entry (head_entry)
    );

    // Serializes each bundle into single result transfers.
    dupd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

// ===== bench/tb_data_uri_payload_decoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_data_uri_payload_decoder
// Self-checking bench for the data URI payload decoder. URI characters are
// streamed in with random gaps. Every accepted character runs through a
// bench-side decoder that queues the bytes and status it should cause. Each
// output transfer is checked field by field against the oldest queued result.
// ---------------------------------------------------------------------------
module tb_data_uri_payload_decoder;

    import dupd_pkg::*;

    // Bench-side decoder phases and escape states
    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_HEADER,
        PH_PAYLOAD,
        PH_REJECTED
    } uri_phase_e;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PCT,
        ESC_DIGIT
    } esc_stage_e;

    localparam logic [39:0] SCHEME_TEXT  = "data:";
    localparam logic [47:0] WORD_TEXT    = "base64";
    localparam int          SCHEME_CHARS = 5;
    localparam int          WORD_CHARS   = 6;
    localparam int          RANDOM_CHARS = 300;
    localparam int          MAX_WAIT     = 8;
    // room for the queue and output register to drain, with margin
    localparam int          DRAIN_CYCLES = 20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    dupd_in_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    dupd_out_t out_item;

    // Results still owed by the block, oldest first
    dupd_out_t  pending_decoded[$];
    logic [7:0] uri_buf[$];

    int chars_sent     = 0;
    int mismatch_count = 0;
    int hold_request   = 0;   // one-shot long output stall, in cycles
    bit tx_idle        = 1'b1;
    bit rx_idle        = 1'b1;

    // Bench-side decoder state
    uri_phase_e uri_phase;
    logic [2:0] scheme_pos;
    logic [2:0] word_pos;
    logic       b64_on;
    logic [11:0] bit_acc;
    logic [3:0] bit_cnt;
    esc_stage_e esc;
    logic [7:0] esc_digit;
    logic       emitted;

    data_uri_payload_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    // -----------------------------------------------------------------------
    // Bench-side decoder
    // -----------------------------------------------------------------------
    function automatic void clear_uri_state();
        uri_phase  = PH_PREFIX;
        scheme_pos = '0;
        word_pos   = '0;
        b64_on     = 1'b0;
        bit_acc    = '0;
        bit_cnt    = '0;
        esc        = ESC_NONE;
        esc_digit  = '0;
        emitted    = 1'b0;
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        dupd_out_t r;
        r            = '0;
        r.byte_out   = b;
        r.byte_valid = 1'b1;
        pending_decoded.push_back(r);
        emitted = 1'b1;
    endfunction

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c >= "0" && c <= "9")
            v = c - "0";
        else if (c >= "a" && c <= "f")
            v = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F")
            v = c - "A" + 8'd10;
        else
            v = 8'd0;
        return v[3:0];
    endfunction

    // -1 for anything outside the alphabet, padding too
    function automatic int sextet_of(input logic [7:0] c);
        int v;
        if (c >= "A" && c <= "Z")
            v = int'(c - "A");
        else if (c >= "a" && c <= "z")
            v = int'(c - "a") + 26;
        else if (c >= "0" && c <= "9")
            v = int'(c - "0") + 52;
        else if (c == "+")
            v = 62;
        else if (c == "/")
            v = 63;
        else
            v = -1;
        return v;
    endfunction

    function automatic void percent_fresh(input logic [7:0] c);
        if (c == CH_PCT)
            esc = ESC_PCT;
        else
            queue_byte(c);
    endfunction

    function automatic void percent_step(input logic [7:0] c);
        case (esc)
            ESC_PCT:
            begin
                if (is_hex(c)) begin
                    esc_digit = c;
                    esc       = ESC_DIGIT;
                end else begin
                    esc = ESC_NONE;
                    queue_byte(CH_PCT);
                    percent_fresh(c);
                end
            end
            ESC_DIGIT:
            begin
                esc = ESC_NONE;
                if (is_hex(c)) begin
                    queue_byte({hex_nibble(esc_digit), hex_nibble(c)});
                end else begin
                    // bad second digit: flush literally, rescan the char
                    queue_byte(CH_PCT);
                    queue_byte(esc_digit);
                    percent_fresh(c);
                end
            end
            default:
            begin
                esc = ESC_NONE;
                percent_fresh(c);
            end
        endcase
    endfunction

    function automatic void base64_step(input logic [7:0] c);
        int v;
        v = sextet_of(c);
        if (v >= 0) begin
            bit_acc = {bit_acc[5:0], 6'(v)};
            bit_cnt = bit_cnt + 4'd6;
            if (bit_cnt >= 4'd8) begin
                bit_cnt = bit_cnt - 4'd8;
                queue_byte(8'(bit_acc >> bit_cnt));
            end
        end
    endfunction

    function automatic void decode_uri_char(input dupd_in_t it);
        logic [7:0] c;
        logic [7:0] lc;
        logic [1:0] st;
        dupd_out_t  r;
        c  = it.char_in;
        lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
        case (uri_phase)
            PH_PREFIX:
            begin
                if (int'(scheme_pos) < SCHEME_CHARS &&
                    lc == SCHEME_TEXT[8*(SCHEME_CHARS-1-int'(scheme_pos)) +: 8]) begin
                    scheme_pos = scheme_pos + 3'd1;
                    if (int'(scheme_pos) == SCHEME_CHARS)
                        uri_phase = PH_HEADER;
                end else begin
                    uri_phase = PH_REJECTED;
                end
            end
            PH_HEADER:
            begin
                if (c == CH_COMMA) begin
                    uri_phase = PH_PAYLOAD;
                end else if (!b64_on) begin
                    // case-sensitive search, a 'b' restarts the match
                    if (int'(word_pos) < WORD_CHARS &&
                        c == WORD_TEXT[8*(WORD_CHARS-1-int'(word_pos)) +: 8])
                        word_pos = word_pos + 3'd1;
                    else
                        word_pos = (c == CH_LOW_B) ? 3'd1 : 3'd0;
                    if (int'(word_pos) == WORD_CHARS)
                        b64_on = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                if (b64_on)
                    base64_step(c);
                else
                    percent_step(c);
            end
            default: ;
        endcase

        if (it.char_last) begin
            // escape cut short by the end: emit what was taken
            if (uri_phase == PH_PAYLOAD && !b64_on) begin
                if (esc == ESC_PCT) begin
                    queue_byte(CH_PCT);
                end else if (esc == ESC_DIGIT) begin
                    queue_byte(CH_PCT);
                    queue_byte(esc_digit);
                end
                esc = ESC_NONE;
            end
            if (uri_phase == PH_HEADER)
                st = ST_NO_COMMA;
            else if (uri_phase == PH_PAYLOAD)
                st = emitted ? ST_OK : ST_EMPTY;
            else
                st = ST_NOT_DATA;
            r          = '0;
            r.done_res = 1'b1;
            r.status   = st;
            pending_decoded.push_back(r);
            clear_uri_state();
        end
    endfunction

    // -----------------------------------------------------------------------
    // Input side
    // -----------------------------------------------------------------------
    // Valid is only dropped when a gap follows, so it never sees two
    // nonblocking writes in the same step.
    task automatic send_char(input logic [7:0] c, input bit last);
        int gap;
        dupd_in_t it;
        gap          = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
        it.char_in   = c;
        it.char_last = last;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_uri_char(it);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input bit ends_uri);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], ends_uri && (i == s.len() - 1));
    endtask

    task automatic send_uri_buf();
        for (int i = 0; i < uri_buf.size(); i++)
            send_char(uri_buf[i], i == uri_buf.size() - 1);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            uri_buf.push_back(s[i]);
    endtask

    // -----------------------------------------------------------------------
    // Output side: random stall per transfer, plus the one-shot long hold
    // -----------------------------------------------------------------------
    initial begin : result_sink
        int wait_cycles;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request > 0) begin
                wait_cycles  = hold_request;
                hold_request = 0;
            end else begin
                wait_cycles = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk) begin : result_check
        dupd_out_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_decoded.size() == 0) begin
                $error("unexpected result: byte_out %0h byte_valid %0b done_res %0b status %0d",
                       out_item.byte_out, out_item.byte_valid, out_item.done_res,
                       out_item.status);
                mismatch_count++;
            end else begin
                want = pending_decoded.pop_front();
                if (out_item.byte_out !== want.byte_out) begin
                    $error("byte_out: expected %0h, got %0h", want.byte_out, out_item.byte_out);
                    mismatch_count++;
                end
                if (out_item.byte_valid !== want.byte_valid) begin
                    $error("byte_valid: expected %0b, got %0b",
                           want.byte_valid, out_item.byte_valid);
                    mismatch_count++;
                end
                if (out_item.done_res !== want.done_res) begin
                    $error("done_res: expected %0b, got %0b", want.done_res, out_item.done_res);
                    mismatch_count++;
                end
                if (out_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_item.status);
                    mismatch_count++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // Wrong first char, and a URI that stops inside the scheme
    task automatic test_not_data_uri();
        send_text("x", 1'b1);
        send_text("dA", 1'b1);
    endtask

    // Scheme matched (upper case) but the header never closes
    task automatic test_no_comma();
        send_text("DATA:", 1'b1);
    endtask

    task automatic test_empty_payload();
        send_text("data:,", 1'b1);
    endtask

    // Byte extremes, bad second digit, '%' after '%', good escapes,
    // bad escape on the last char (four results), escape cut by the end
    task automatic test_percent_escapes();
        send_text("data:,", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b0);
        send_text("%4g%%41%2F%4x", 1'b1);
        send_text("data:,%a", 1'b1);
    endtask

    // Header match restarting on a repeated 'b'; '+', '/', padding skipped,
    // leftover bits dropped at the end
    task automatic test_base64();
        send_text("data:bbase64,+/8=", 1'b1);
    endtask

    // Receiver holds off while the sender keeps offering one-byte chars:
    // the result queue fills and in_ready has to drop.
    task automatic test_output_backpressure();
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_request = 80;
        send_text("data:,", 1'b0);
        for (int i = 0; i < 40; i++)
            send_char(8'("a" + (i % 26)), i == 39);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    function automatic logic [7:0] header_filler();
        logic [7:0] ch;
        case ($urandom_range(0, 5))
            0: ch = ";";
            1: ch = "b";
            2: ch = "=";
            3: ch = "4";
            4: ch = 8'("a" + $urandom_range(0, 25));
            default:
            begin
                ch = 8'($urandom_range(0, 255));
                if (ch == CH_COMMA)
                    ch = ";";
            end
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] payload_char(input bit b64_style);
        int sel;
        int v;
        logic [7:0] ch;
        sel = $urandom_range(0, 9);
        if (b64_style) begin
            if (sel < 7) begin
                v = $urandom_range(0, 63);
                if (v < 26)
                    ch = 8'("A" + v);
                else if (v < 52)
                    ch = 8'("a" + v - 26);
                else if (v < 62)
                    ch = 8'("0" + v - 52);
                else
                    ch = (v == 62) ? "+" : "/";
            end else if (sel == 7) begin
                ch = "=";
            end else begin
                ch = 8'($urandom_range(0, 255));
            end
        end else begin
            if (sel < 3) begin
                ch = CH_PCT;
            end else if (sel < 6) begin
                v = $urandom_range(0, 21);
                if (v < 10)
                    ch = 8'("0" + v);
                else if (v < 16)
                    ch = 8'("a" + v - 10);
                else
                    ch = 8'("A" + v - 16);
            end else if (sel < 8) begin
                ch = 8'($urandom_range(0, 255));
            end else begin
                ch = 8'("g" + $urandom_range(0, 19));
            end
        end
        return ch;
    endfunction

    // Mostly well-formed URIs with random content; some with a broken
    // scheme, a missing comma, or cut off at a random point.
    task automatic build_random_uri();
        int flavor;
        int hdr_len;
        int pay_len;
        int keep;
        bit b64_hdr;
        logic [7:0] ch;
        uri_buf.delete();
        flavor = $urandom_range(0, 19);
        for (int i = 0; i < SCHEME_CHARS; i++) begin
            ch = SCHEME_TEXT[8*(SCHEME_CHARS-1-i) +: 8];
            if (ch != ":" && $urandom_range(0, 1))
                ch = ch - 8'h20;
            uri_buf.push_back(ch);
        end
        if (flavor == 0)
            uri_buf[$urandom_range(0, SCHEME_CHARS - 1)] = 8'($urandom_range(0, 255));

        b64_hdr = $urandom_range(0, 1);
        hdr_len = $urandom_range(0, 3);
        for (int i = 0; i < hdr_len; i++)
            uri_buf.push_back(header_filler());
        if (b64_hdr) begin
            case ($urandom_range(0, 5))
                0: push_text("bbase64");
                1: push_text("BASE64");
                2: push_text("base6");
                3: push_text("basE64");
                default: push_text("base64");
            endcase
            hdr_len = $urandom_range(0, 2);
            for (int i = 0; i < hdr_len; i++)
                uri_buf.push_back(header_filler());
        end

        if (flavor != 1)
            uri_buf.push_back(CH_COMMA);

        pay_len = $urandom_range(0, 14);
        for (int i = 0; i < pay_len; i++)
            uri_buf.push_back(payload_char($urandom_range(0, 9) == 0 ? !b64_hdr : b64_hdr));

        if (flavor == 2) begin
            keep = $urandom_range(1, uri_buf.size());
            while (uri_buf.size() > keep)
                void'(uri_buf.pop_back());
        end
    endtask

    task automatic test_random_uris();
        int target;
        target = chars_sent + RANDOM_CHARS;
        while (chars_sent < target) begin
            // some URIs run with no idling on one side or both
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            build_random_uri();
            send_uri_buf();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        clear_uri_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_not_data_uri();
        test_no_comma();
        test_empty_payload();
        test_percent_escapes();
        test_base64();
        test_output_backpressure();
        test_random_uris();
        in_valid <= 1'b0;

        while (pending_decoded.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_decoded.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far above the slowest legal run
    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
